// ===== rtl/core/wdr_pkg.sv =====
`default_nettype none
package wdr_pkg;

  // Defaults for the top-level parameters.
  localparam int CORDIC_STEPS_DEF          = 18;
  localparam int RESULT_FRACTION_BITS_DEF  = 16;

  // Fixed field widths.
  localparam int OUT_W  = 18;
  localparam int ANG_W  = 24;
  localparam int RED_W  = 17;   // reduced angle, below one full turn
  localparam int PH_W   = 20;   // phase sum before reduction
  localparam int X_W    = 34;   // CORDIC vector, Q2.30 with headroom
  localparam int Z_W    = 30;   // CORDIC angle, degrees with 20 fraction bits
  localparam int CS_W   = 32;   // clamped cosine and sine
  localparam int T_W    = 36;   // small-d intermediate

  // Angle constants, degrees with 8 fraction bits.
  localparam int FULL_TURN    = 92160;
  localparam int HALF_TURN    = 46080;
  localparam int QUARTER_TURN = 23040;
  localparam int WRAP_OFFSET  = 8478720;     // 92 full turns
  localparam int RECIP_SHIFT  = 40;
  localparam longint RECIP    = 64'd11930464; // floor(2^40 / 92160)

  // Q2.30 constants.
  localparam longint ONE_Q30  = 64'd1073741824;
  localparam longint GAIN_INV = 64'd652032874;
  localparam longint ROOT_3_8 = 64'd657529896;
  localparam longint ROOT_3_2 = 64'd1315059792;

  typedef enum logic [1:0] {
    MODE_ZERO,
    MODE_ONE,
    MODE_FULL
  } mode_e;

  typedef enum logic [1:0] {
    SH_30,
    SH_31,
    SH_32
  } shift_e;

  typedef enum logic [1:0] {
    POST_NONE,
    POST_R38,
    POST_R32,
    POST_C2
  } post_e;

  typedef struct packed {
    logic signed [X_W-1:0] x;
    logic signed [X_W-1:0] y;
    logic signed [Z_W-1:0] z;
  } rot_t;

  typedef struct packed {
    mode_e             mode;
    logic signed [2:0] k;
    logic signed [2:0] m;
    logic              flip_b;
    logic              flip_p;
  } side_t;

  typedef struct packed {
    mode_e                  mode;
    logic signed [CS_W-1:0] cph;
    logic signed [CS_W-1:0] sph;
  } tail_t;

  // Arctangent of 2^-i in degrees with 20 fraction bits.
  function automatic logic [26:0] atan_deg20(input int unsigned i);
    logic [26:0] v;
    case (i)
      0:  v = 27'd47185920;
      1:  v = 27'd27855475;
      2:  v = 27'd14718068;
      3:  v = 27'd7471121;
      4:  v = 27'd3750058;
      5:  v = 27'd1876857;
      6:  v = 27'd938658;
      7:  v = 27'd469357;
      8:  v = 27'd234682;
      9:  v = 27'd117342;
      10: v = 27'd58671;
      11: v = 27'd29335;
      12: v = 27'd14668;
      13: v = 27'd7334;
      14: v = 27'd3667;
      15: v = 27'd1833;
      16: v = 27'd917;
      17: v = 27'd458;
      18: v = 27'd229;
      19: v = 27'd115;
      20: v = 27'd57;
      21: v = 27'd29;
      22: v = 27'd14;
      23: v = 27'd7;
      24: v = 27'd4;
      25: v = 27'd2;
      26: v = 27'd1;
      default: v = 27'd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/wdr_if.sv =====
`default_nettype none
// Input channel: one Wigner element request per transaction.
interface wdr_in_if;
  import wdr_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [3:0]              rank;
  logic signed [3:0]       left_index;
  logic signed [3:0]       right_index;
  logic signed [ANG_W-1:0] angle_first;
  logic signed [ANG_W-1:0] angle_second;
  logic signed [ANG_W-1:0] angle_third;

  modport source (output valid, rank, left_index, right_index, angle_first,
                  angle_second, angle_third, input ready);
  modport sink (input valid, rank, left_index, right_index, angle_first,
                angle_second, angle_third, output ready);
endinterface

// Output channel: one complex result per transaction.
interface wdr_out_if;
  import wdr_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] real_part;
  logic signed [OUT_W-1:0] imag_part;

  modport source (output valid, real_part, imag_part, input ready);
  modport sink (input valid, real_part, imag_part, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/wdr_cordic_cell.sv =====
`default_nettype none
// One CORDIC iteration for both rotators, registered.
module wdr_cordic_cell
  import wdr_pkg::*;
#(
  parameter int IDX = 0
) (
  input  wire   clk_i,
  input  wire   rst_ni,
  input  wire   en_i,
  input  wire   vld_i,
  input  side_t side_i,
  input  rot_t  rb_i,
  input  rot_t  rp_i,
  output logic  vld_o,
  output side_t side_o,
  output rot_t  rb_o,
  output rot_t  rp_o
);

  localparam logic signed [Z_W-1:0] ATAN = Z_W'(atan_deg20(IDX));

  logic  vld_q;
  side_t side_q;
  rot_t  rb_q, rp_q, rb_d, rp_d;

  function automatic rot_t step(input rot_t r);
    rot_t o;
    logic signed [X_W-1:0] xs, ys;
    xs = r.x >>> IDX;
    ys = r.y >>> IDX;
    if (!r.z[Z_W-1]) begin
      o.x = r.x - ys;
      o.y = r.y + xs;
      o.z = r.z - ATAN;
    end else begin
      o.x = r.x + ys;
      o.y = r.y - xs;
      o.z = r.z + ATAN;
    end
    return o;
  endfunction

  // Micro-rotation toward a zero residual angle.
  always_comb begin
    rb_d = step(rb_i);
    rp_d = step(rp_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q <= side_i;
      rb_q   <= rb_d;
      rp_q   <= rp_d;
    end
  end

  assign vld_o  = vld_q;
  assign side_o = side_q;
  assign rb_o   = rb_q;
  assign rp_o   = rp_q;

endmodule
`default_nettype wire

// ===== rtl/core/wdr_small_d.sv =====
`default_nettype none
// Five-stage pipeline for the rank-two small-d entry d(k, m; beta).
module wdr_small_d
  import wdr_pkg::*;
(
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire                     en_i,
  input  wire                     vld_i,
  input  wire signed [2:0]        k_i,
  input  wire signed [2:0]        m_i,
  input  wire signed [CS_W-1:0]   c_i,
  input  wire signed [CS_W-1:0]   s_i,
  input  tail_t                   tail_i,
  output logic                    vld_o,
  output logic signed [T_W-1:0]   dv_o,
  output tail_t                   tail_o
);

  localparam int OP_W = 35;
  localparam int P1_W = 2 * OP_W;
  localparam int P2_W = T_W + CS_W;
  localparam logic signed [OP_W-1:0] ONE_OP = OP_W'(ONE_Q30);
  localparam logic signed [CS_W-1:0] R38 = CS_W'(ROOT_3_8);
  localparam logic signed [CS_W-1:0] R32 = CS_W'(ROOT_3_2);
  localparam logic signed [T_W-1:0]  ONE_M1 = T_W'(ONE_Q30 - 64'd1);

  logic          vld_q [5];
  tail_t         tail_q [5];

  logic [2:0]    kk, mm;
  logic [4:0]    idx;
  logic signed [OP_W-1:0] c, s, pc, mc, cm, c2m, c2p, ns;
  logic signed [OP_W-1:0] a_d, b_d, a_q, b_q;
  shift_e        sh_d, sh_q, sh_q2;
  post_e         post_d, post_q1, post_q2, post_q3, post_q4;
  logic signed [P1_W-1:0] p1_q;
  logic signed [T_W-1:0]  t_d, t_q, t_q4, dv_d, dv_q;
  logic signed [P2_W-1:0] p2_q;

  // Operand selection for the first product.
  always_comb begin
    kk  = 3'(k_i + 3'sd2);
    mm  = 3'(m_i + 3'sd2);
    idx = 5'(5'(kk) * 5'd5 + 5'(mm));
    c   = OP_W'(c_i);
    s   = OP_W'(s_i);
    ns  = -s;
    pc  = ONE_OP + c;
    mc  = ONE_OP - c;
    cm  = c - ONE_OP;
    c2m = (c <<< 1) - ONE_OP;
    c2p = (c <<< 1) + ONE_OP;
    a_d    = '0;
    b_d    = '0;
    sh_d   = SH_30;
    post_d = POST_NONE;
    case (idx)
      5'd24, 5'd0: begin
        a_d = pc; b_d = pc; sh_d = SH_32;
      end
      5'd23, 5'd5: begin
        a_d = ns; b_d = pc; sh_d = SH_31;
      end
      5'd19, 5'd1: begin
        a_d = s; b_d = pc; sh_d = SH_31;
      end
      5'd2, 5'd10, 5'd22, 5'd14: begin
        a_d = s; b_d = s; post_d = POST_R38;
      end
      5'd21, 5'd15: begin
        a_d = s; b_d = cm; sh_d = SH_31;
      end
      5'd3, 5'd9: begin
        a_d = ns; b_d = cm; sh_d = SH_31;
      end
      5'd20, 5'd4: begin
        a_d = mc; b_d = mc; sh_d = SH_32;
      end
      5'd18, 5'd6: begin
        a_d = c2m; b_d = pc; sh_d = SH_31;
      end
      5'd16, 5'd8: begin
        a_d = c2p; b_d = mc; sh_d = SH_31;
      end
      5'd17, 5'd11: begin
        a_d = ns; b_d = c; post_d = POST_R32;
      end
      5'd13, 5'd7: begin
        a_d = s; b_d = c; post_d = POST_R32;
      end
      5'd12: begin
        a_d = c; b_d = c; post_d = POST_C2;
      end
      default: begin
        a_d = '0;
      end
    endcase
  end

  // Rounded scaling of the first product.
  always_comb begin
    case (sh_q2)
      SH_30:   t_d = T_W'((p1_q + (P1_W'(1) <<< 29)) >>> 30);
      SH_31:   t_d = T_W'((p1_q + (P1_W'(1) <<< 30)) >>> 31);
      SH_32:   t_d = T_W'((p1_q + (P1_W'(1) <<< 31)) >>> 32);
      default: t_d = '0;
    endcase
  end

  // Final form of the entry.
  always_comb begin
    case (post_q4)
      POST_R38, POST_R32: dv_d = T_W'((p2_q + (P2_W'(1) <<< 29)) >>> 30);
      POST_C2:            dv_d = (t_q4 + (t_q4 <<< 1) - ONE_M1) >>> 1;
      default:            dv_d = t_q4;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 5; i++) vld_q[i] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= vld_i;
      for (int i = 1; i < 5; i++) vld_q[i] <= vld_q[i-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tail_q[0] <= tail_i;
      for (int i = 1; i < 5; i++) tail_q[i] <= tail_q[i-1];
      a_q     <= a_d;
      b_q     <= b_d;
      sh_q    <= sh_d;
      post_q1 <= post_d;
      p1_q    <= a_q * b_q;
      sh_q2   <= sh_q;
      post_q2 <= post_q1;
      t_q     <= t_d;
      post_q3 <= post_q2;
      p2_q    <= P2_W'(t_q) * P2_W'((post_q3 == POST_R38) ? R38 : R32);
      t_q4    <= t_q;
      post_q4 <= post_q3;
      dv_q    <= dv_d;
    end
  end

  assign vld_o  = vld_q[4];
  assign tail_o = tail_q[4];
  assign dv_o   = dv_q;

endmodule
`default_nettype wire

// ===== rtl/core/wigner_d_rank2_element_unit.sv =====
`default_nettype none
// Channel   Dir  Transaction payload
// in_i      in   rank, left_index, right_index, angle_first/second/third
// out_o     out  real_part, imag_part
//
// One transaction is accepted per cycle while no result is stalled at the output;
// each result passes through the angle reduction stages, the chain of CORDIC cells,
// the small-d multiplier stages and the phase product and output registers.
// Reset clears only the valid bits of the pipeline.
// The whole pipeline holds while a result waits in the output register.
module wigner_d_rank2_element_unit
  import wdr_pkg::*;
#(
  parameter int CORDIC_STEPS         = CORDIC_STEPS_DEF,
  parameter int RESULT_FRACTION_BITS = RESULT_FRACTION_BITS_DEF
) (
  input  wire      clk_i,
  input  wire      rst_ni,
  wdr_in_if.sink   in_i,
  wdr_out_if.source out_o
);

  localparam int FS   = 60 - RESULT_FRACTION_BITS;
  localparam int PR_W = 70;
  localparam logic signed [PR_W-1:0] LIM = PR_W'(1) <<< RESULT_FRACTION_BITS;
  localparam logic signed [PR_W-1:0] RND = PR_W'(1) <<< (FS - 1);

  logic en;
  logic out_vld_q;
  logic signed [OUT_W-1:0] real_q, imag_q;

  // Pipeline advances unless a result is stalled at the output.
  assign en         = !out_vld_q || out_o.ready;
  assign in_i.ready = en;

  // Pipeline valid bits and side information for stages 1 to 5.
  logic  s1_vld, s2_vld, s3_vld, s4_vld, s5_vld;
  side_t s1_side, s2_side, s3_side, s4_side, s5_side, s5_side_d;
  rot_t  rb5_q, rp5_q;

  // Request classification.
  logic [3:0] kabs, mabs;
  side_t      side_in;
  logic signed [ANG_W-1:0] ang_in [3];

  always_comb begin
    kabs = in_i.left_index[3] ? 4'(-in_i.left_index) : in_i.left_index;
    mabs = in_i.right_index[3] ? 4'(-in_i.right_index) : in_i.right_index;
    side_in.k      = in_i.left_index[2:0];
    side_in.m      = in_i.right_index[2:0];
    side_in.flip_b = 1'b0;
    side_in.flip_p = 1'b0;
    if ((in_i.rank != 4'd0 && in_i.rank != 4'd2) || kabs > in_i.rank ||
        mabs > in_i.rank) begin
      side_in.mode = MODE_ZERO;
    end else if (in_i.rank == 4'd0) begin
      side_in.mode = MODE_ONE;
    end else begin
      side_in.mode = MODE_FULL;
    end
    ang_in[0] = in_i.angle_first;
    ang_in[1] = in_i.angle_second;
    ang_in[2] = in_i.angle_third;
  end

  // Stage 1: offset to positive and estimate the turn count.
  logic [24:0] u_d [3];
  logic [24:0] u_q [3];
  logic [7:0]  q_d [3];
  logic [7:0]  q_q [3];
  logic [48:0] qp [3];

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      u_d[j] = 25'($signed({ang_in[j][ANG_W-1], ang_in[j]}) + 25'(WRAP_OFFSET));
      qp[j]  = 49'(u_d[j]) * 49'(RECIP);
      q_d[j] = 8'(qp[j] >> RECIP_SHIFT);
    end
  end

  // Stage 2: remainder, one correction step.
  logic [24:0]      r_full [3];
  logic [RED_W-1:0] r_d [3];
  logic [RED_W-1:0] r_q [3];

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      r_full[j] = u_q[j] - 25'(25'(q_q[j]) * 25'(FULL_TURN));
      if (r_full[j] >= 25'(FULL_TURN)) begin
        r_d[j] = RED_W'(r_full[j] - 25'(FULL_TURN));
      end else begin
        r_d[j] = RED_W'(r_full[j]);
      end
    end
  end

  // Stage 3: phase k*alpha + m*gamma, offset by four turns.
  logic signed [21:0] ka, mg;
  logic [PH_W-1:0]    ph_d, ph_q;
  logic [RED_W-1:0]   b3_q;

  always_comb begin
    ka   = $signed({5'b0, r_q[0]}) * 22'(s2_side.k);
    mg   = $signed({5'b0, r_q[2]}) * 22'(s2_side.m);
    ph_d = PH_W'(ka + mg + 22'sd368640);
  end

  // Stage 4: reduce the phase below one turn.
  logic [PH_W-1:0]  p4a, p4b;
  logic [RED_W-1:0] ph4_d, ph4_q, b4_q;

  always_comb begin
    p4a   = (ph_q >= PH_W'(4 * FULL_TURN)) ? ph_q - PH_W'(4 * FULL_TURN) : ph_q;
    p4b   = (p4a >= PH_W'(2 * FULL_TURN)) ? p4a - PH_W'(2 * FULL_TURN) : p4a;
    ph4_d = RED_W'((p4b >= PH_W'(FULL_TURN)) ? p4b - PH_W'(FULL_TURN) : p4b);
  end

  // Stage 5: fold into [-90, 90] degrees and load the CORDIC chain.
  function automatic logic [Z_W:0] fold(input logic [RED_W-1:0] a);
    logic signed [RED_W:0] sa;
    logic                  fl;
    sa = $signed({1'b0, a});
    if (a >= RED_W'(HALF_TURN)) sa = sa - (RED_W+1)'(FULL_TURN);
    fl = 1'b0;
    if (sa > (RED_W+1)'(QUARTER_TURN)) begin
      sa = sa - (RED_W+1)'(HALF_TURN);
      fl = 1'b1;
    end else if (sa < -(RED_W+1)'(QUARTER_TURN)) begin
      sa = sa + (RED_W+1)'(HALF_TURN);
      fl = 1'b1;
    end
    return {fl, Z_W'(sa) <<< 12};
  endfunction

  logic [Z_W:0] fb, fp;
  assign fb = fold(b4_q);
  assign fp = fold(ph4_q);

  // Side information entering the chain carries the fold flags.
  always_comb begin
    s5_side_d        = s4_side;
    s5_side_d.flip_b = fb[Z_W];
    s5_side_d.flip_p = fp[Z_W];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld <= 1'b0;
      s2_vld <= 1'b0;
      s3_vld <= 1'b0;
      s4_vld <= 1'b0;
      s5_vld <= 1'b0;
    end else if (en) begin
      s1_vld <= in_i.valid;
      s2_vld <= s1_vld;
      s3_vld <= s2_vld;
      s4_vld <= s3_vld;
      s5_vld <= s4_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_side <= side_in;
      u_q     <= u_d;
      q_q     <= q_d;
      s2_side <= s1_side;
      r_q     <= r_d;
      s3_side <= s2_side;
      ph_q    <= ph_d;
      b3_q    <= r_q[1];
      s4_side <= s3_side;
      ph4_q   <= ph4_d;
      b4_q    <= b3_q;
      s5_side <= s5_side_d;
      rb5_q   <= '{x: X_W'(GAIN_INV), y: '0, z: fb[Z_W-1:0]};
      rp5_q   <= '{x: X_W'(GAIN_INV), y: '0, z: fp[Z_W-1:0]};
    end
  end

  // Chain of CORDIC cells.
  logic  cv [CORDIC_STEPS+1];
  side_t cs [CORDIC_STEPS+1];
  rot_t  cb [CORDIC_STEPS+1];
  rot_t  cp [CORDIC_STEPS+1];

  assign cv[0] = s5_vld;
  assign cs[0] = s5_side;
  assign cb[0] = rb5_q;
  assign cp[0] = rp5_q;

  for (genvar gi = 0; gi < CORDIC_STEPS; gi++) begin : g_cell
    wdr_cordic_cell #(.IDX(gi)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .vld_i  (cv[gi]),
      .side_i (cs[gi]),
      .rb_i   (cb[gi]),
      .rp_i   (cp[gi]),
      .vld_o  (cv[gi+1]),
      .side_o (cs[gi+1]),
      .rb_o   (cb[gi+1]),
      .rp_o   (cp[gi+1])
    );
  end

  // Sign fix-up and clamp to one.
  function automatic logic signed [CS_W-1:0] clamp1(input logic signed [X_W-1:0] v,
                                                    input logic fl);
    logic signed [X_W-1:0] w;
    w = fl ? -v : v;
    if (w > X_W'(ONE_Q30)) return CS_W'(ONE_Q30);
    if (w < -X_W'(ONE_Q30)) return -CS_W'(ONE_Q30);
    return CS_W'(w);
  endfunction

  logic                   pv_q;
  logic signed [2:0]      pk_q, pm_q;
  logic signed [CS_W-1:0] cb_q, sb_q;
  tail_t                  ptail_q;
  side_t                  cl;

  assign cl = cs[CORDIC_STEPS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q <= 1'b0;
    end else if (en) begin
      pv_q <= cv[CORDIC_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pk_q    <= cl.k;
      pm_q    <= cl.m;
      cb_q    <= clamp1(cb[CORDIC_STEPS].x, cl.flip_b);
      sb_q    <= clamp1(cb[CORDIC_STEPS].y, cl.flip_b);
      ptail_q <= '{mode: cl.mode,
                   cph:  clamp1(cp[CORDIC_STEPS].x, cl.flip_p),
                   sph:  clamp1(cp[CORDIC_STEPS].y, cl.flip_p)};
    end
  end

  // Small-d entry of beta.
  logic                  dv_vld;
  logic signed [T_W-1:0] dv;
  tail_t                 dtail;

  wdr_small_d u_small_d (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (pv_q),
    .k_i    (pk_q),
    .m_i    (pm_q),
    .c_i    (cb_q),
    .s_i    (sb_q),
    .tail_i (ptail_q),
    .vld_o  (dv_vld),
    .dv_o   (dv),
    .tail_o (dtail)
  );

  // Complex phase products.
  logic                   f_vld_q;
  mode_e                  f_mode_q;
  logic signed [PR_W-1:0] pr_q, pi_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_vld_q <= 1'b0;
    end else if (en) begin
      f_vld_q <= dv_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      f_mode_q <= dtail.mode;
      pr_q     <= PR_W'(dv) * PR_W'(dtail.cph);
      pi_q     <= PR_W'(dv) * PR_W'(-(CS_W+1)'(dtail.sph));
    end
  end

  // Rounding, saturation and result selection.
  function automatic logic signed [OUT_W-1:0] finish(input logic signed [PR_W-1:0] p);
    logic signed [PR_W-1:0] v;
    v = (p + RND) >>> FS;
    if (v > LIM) v = LIM;
    if (v < -LIM) v = -LIM;
    return v[OUT_W-1:0];
  endfunction

  logic signed [OUT_W-1:0] real_d, imag_d;

  always_comb begin
    case (f_mode_q)
      MODE_FULL: begin
        real_d = finish(pr_q);
        imag_d = finish(pi_q);
      end
      MODE_ONE: begin
        real_d = LIM[OUT_W-1:0];
        imag_d = '0;
      end
      default: begin
        real_d = '0;
        imag_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= f_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      real_q <= real_d;
      imag_q <= imag_d;
    end
  end

  assign out_o.valid     = out_vld_q;
  assign out_o.real_part = real_q;
  assign out_o.imag_part = imag_q;

endmodule
`default_nettype wire

// ===== rtl/core/wdr_checker.sv =====
`default_nettype none
// Port-level checks on the element unit.
module wdr_checker
  import wdr_pkg::*;
(
  input wire                    clk_i,
  input wire                    rst_ni,
  input wire                    in_ready_i,
  input wire                    out_valid_i,
  input wire                    out_ready_i,
  input wire signed [OUT_W-1:0] real_i,
  input wire signed [OUT_W-1:0] imag_i
);

  // A stalled result holds its value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(real_i) && $stable(imag_i))
    else $error("stalled result changed");

  // No result is shown during reset.
  assert property (@(posedge clk_i) !rst_ni |-> !out_valid_i)
    else $error("result valid during reset");

  // The unit only stops taking requests while a result is stalled.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input stalled with empty output");

  // Both parts stay within plus or minus one at 16 fraction bits.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> real_i[17:16] != 2'b10 && (real_i[17:16] != 2'b01 || real_i[15:0] == 16'd0)
                 && imag_i[17:16] != 2'b10 && (imag_i[17:16] != 2'b01 || imag_i[15:0] == 16'd0))
    else $error("result magnitude beyond one");

endmodule

bind wigner_d_rank2_element_unit wdr_checker u_wdr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .real_i      (out_o.real_part),
  .imag_i      (out_o.imag_part)
);
`default_nettype wire
